// ===== rtl/upc_pkg.sv =====
// Shared types, character constants and helper functions of the URL percent codec.
`default_nettype none

package upc_pkg;

  // Item that enters the codec.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last_in;
  } in_item_t;

  // Item that leaves the codec.
  typedef struct packed {
    logic [7:0] char_out;
    logic       has_byte;
    logic       last_out;
  } out_item_t;

  // Work handed from the classifier to the emitter.
  typedef enum logic [0:0] {
    CMD_BYTE   = 1'b0,
    CMD_ESCAPE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } cmd_t;

  // Mode register values.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Configuration address map.
  localparam int unsigned PADDR_W = 3;

  // Escape position of the last hex digit.
  localparam logic [1:0] ESC_LAST_IDX = 2'd2;

  // Characters with a special meaning.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // True for bytes that pass through encoding unchanged.
  function automatic logic is_plain(input logic [7:0] c);
    logic res;
    res = ((c >= CH_ZERO) && (c <= CH_NINE)) ||
          ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
          ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
          (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
    return res;
  endfunction

  // Value of a hex digit; other bytes wrap as lowercase minus 'a' plus ten.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] res;
    lc = c;
    if ((c >= CH_UP_A) && (c <= CH_UP_Z)) begin
      lc = c + (CH_LOW_A - CH_UP_A);
    end
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      res = c - CH_ZERO;
    end else begin
      res = lc - CH_LOW_A + HEX_TEN;
    end
    return res;
  endfunction

  // Lowercase hex character for a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] res;
    if (n < 4'd10) begin
      res = CH_ZERO + {4'd0, n};
    end else begin
      res = CH_LOW_A + {4'd0, n} - HEX_TEN;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/upc_front.sv =====
// Front end: accepts input items, tracks the decode escape state and issues commands.
`default_nettype none

module upc_front
  import upc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     mode,
  input  wire in_item_t in_item,
  input  wire logic     accept,
  output cmd_t          cmd,
  output logic          cmd_push
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_digit;
  logic [7:0] held_next;
  cmd_t       tail_cmd;
  logic [7:0] hi_val;
  logic [7:0] lo_val;
  logic [7:0] decoded;

  // Ordinary decode of a byte that does not open or continue an escape.
  always_comb begin
    tail_cmd.kind     = CMD_BYTE;
    tail_cmd.data     = in_item.char_in;
    tail_cmd.has_byte = 1'b1;
    tail_cmd.last     = in_item.last_in;
    if (in_item.char_in == CH_PERCENT) begin
      // A dangling percent is dropped; only reached on the final byte.
      tail_cmd.data     = 8'd0;
      tail_cmd.has_byte = 1'b0;
      tail_cmd.last     = 1'b1;
    end else if (in_item.char_in == CH_PLUS) begin
      tail_cmd.data = CH_SPACE;
    end
  end

  // Byte formed from the held digit and the current one.
  assign hi_val  = digit_value(held_digit);
  assign lo_val  = digit_value(in_item.char_in);
  assign decoded = {hi_val[3:0], 4'd0} | lo_val;

  // Classification of the current item.
  always_comb begin
    cmd        = tail_cmd;
    cmd_push   = 1'b0;
    phase_next = phase;
    held_next  = held_digit;
    if (mode == MODE_ENCODE) begin
      phase_next   = PH_IDLE;
      cmd_push     = 1'b1;
      cmd.kind     = CMD_BYTE;
      cmd.data     = in_item.char_in;
      cmd.has_byte = 1'b1;
      cmd.last     = in_item.last_in;
      if (is_plain(in_item.char_in)) begin
        cmd.kind = CMD_BYTE;
      end else if (in_item.char_in == CH_SPACE) begin
        cmd.data = CH_PLUS;
      end else begin
        cmd.kind = CMD_ESCAPE;
      end
    end else begin
      unique case (phase)
        PH_DIGIT: begin
          phase_next   = PH_IDLE;
          cmd_push     = 1'b1;
          cmd.kind     = CMD_BYTE;
          cmd.data     = decoded;
          cmd.has_byte = 1'b1;
          cmd.last     = in_item.last_in;
        end
        PH_PCT: begin
          if (!in_item.last_in) begin
            held_next  = in_item.char_in;
            phase_next = PH_DIGIT;
          end else begin
            phase_next = PH_IDLE;
            cmd_push   = 1'b1;
          end
        end
        PH_IDLE: begin
          if ((in_item.char_in == CH_PERCENT) && !in_item.last_in) begin
            phase_next = PH_PCT;
          end else begin
            cmd_push = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          cmd_push   = 1'b1;
        end
      endcase
    end
  end

  // Escape state moves only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_digit <= 8'd0;
    end else if (accept) begin
      held_digit <= held_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/upc_fifo.sv =====
// Small flip-flop queue of commands between the front end and the emitter.
`default_nettype none

module upc_fifo
  import upc_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output cmd_t      rdata
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/upc_back.sv =====
// Emitter: expands commands into result items and holds the output register.
`default_nettype none

module upc_back
  import upc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output out_item_t out_item,
  output logic      empty,
  input  wire logic pop
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  out_item_t  next_item;

  assign empty = !out_valid;
  assign load  = q_valid && (!out_valid || pop);
  assign q_pop = load && ((q_cmd.kind == CMD_BYTE) || (idx == ESC_LAST_IDX));

  // Result for the current command and escape position.
  always_comb begin
    next_item.char_out = q_cmd.data;
    next_item.has_byte = q_cmd.has_byte;
    next_item.last_out = q_cmd.last;
    if (q_cmd.kind == CMD_ESCAPE) begin
      next_item.has_byte = 1'b1;
      case (idx)
        2'd0: begin
          next_item.char_out = CH_PERCENT;
          next_item.last_out = 1'b0;
        end
        2'd1: begin
          next_item.char_out = hex_char(q_cmd.data[7:4]);
          next_item.last_out = 1'b0;
        end
        default: begin
          next_item.char_out = hex_char(q_cmd.data[3:0]);
        end
      endcase
    end
  end

  // Output register and escape position.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        idx <= 2'd0;
      end else if (load) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= next_item;
    end
  end

`ifndef SYNTHESIS
  // An escape in progress keeps its command at the head of the queue.
  a_idx_holds_head: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd0) |-> q_valid)
    else $error("escape position set without a queued command");

  // An escape always opens with a percent sign that does not end the string.
  a_escape_opens: assert property (@(posedge clk) disable iff (rst)
    (load && (q_cmd.kind == CMD_ESCAPE) && (idx == 2'd0)) |=>
      ((out_item.char_out == CH_PERCENT) && !out_item.last_out))
    else $error("escape did not start with a percent sign");

  // An end marker only ever closes a string.
  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.has_byte) |-> out_item.last_out)
    else $error("end marker without last flag");
`endif

endmodule

`default_nettype wire

// ===== rtl/url_percent_codec.sv =====
// Top level of the URL percent codec: configuration port and the three stages.
`default_nettype none

// Converts a byte string in the form-urlencoded style, one input item per cycle
// while full is low. The mode register (address 0, bit 0) selects encoding (0)
// or decoding (1) and should be written only while no string is in flight.
// Decoding and plain bytes of encoding produce at most one result per cycle, so
// while results are popped input and output run at one item per cycle. An
// escaped byte in encoding gives three results which the emitter sends in turn;
// the command queue of QUEUE_DEPTH entries absorbs the input meanwhile, and push
// stalls (full high) once it fills. A percent sign and the first hex digit of an
// escape in decoding are taken in without a result. An accepted item's first
// result is registered in the command queue and then in the output register.
module url_percent_codec
  import upc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               push,
  input  wire in_item_t           in_item,
  output logic                    full,
  output logic                    empty,
  input  wire logic               pop,
  output out_item_t               out_item
);

  logic mode;
  logic reg_sel;
  logic accept;
  cmd_t front_cmd;
  logic front_push;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == 1'b0);
  assign prdata  = reg_sel ? {31'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      mode <= pwdata[0];
    end
  end

  assign accept = push && !full;

  upc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .in_item  (in_item),
    .accept   (accept),
    .cmd      (front_cmd),
    .cmd_push (front_push)
  );

  upc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept && front_push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_cmd)
  );

  upc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

`default_nettype wire
